// File: hdl/mlsbs_pkg.sv
// Shared types and constants of the multilevel slot budget scheduler.
package mlsbs_pkg;

	localparam int TAG_W = 16;
	localparam logic [TAG_W-1:0] TAG_MAX = 16'hFFFF;

	localparam logic [1:0] OP_ENQ   = 2'd0;
	localparam logic [1:0] OP_DEQ   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic accept;   // input side ready
		logic load;     // capture the request
		logic enq;      // enqueue or reject
		logic scan_clr; // restart the level scan
		logic minmax;   // min/max pass step
		logic match;    // candidate pass step
		logic pop;      // serve the chosen level
		logic clear;    // zero slots and tags
		logic finish;   // load the output register
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       none_queued;
		logic       scan_last;
		logic       out_busy;
	} dp_stat_t;

endpackage

// File: hdl/mlsbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mlsbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hdl/mlsbs_ctrl.sv
// Controller state machine of the multilevel slot budget scheduler.
module mlsbs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  mlsbs_pkg::dp_stat_t stat,
	output mlsbs_pkg::ctl_cmd_t cmd
);
	import mlsbs_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_MINMAX = 3'd2;
	localparam logic [2:0] ST_MATCH  = 3'd3;
	localparam logic [2:0] ST_POP    = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0] state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_nx = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.scan_clr = 1'b1;
				state_nx     = ST_FINISH;
				case (stat.op)
					OP_ENQ:   cmd.enq = 1'b1;
					OP_DEQ:   if (!stat.none_queued) state_nx = ST_MINMAX;
					OP_CLEAR: cmd.clear = 1'b1;
					default:  ;
				endcase
			end
			ST_MINMAX: begin
				cmd.minmax = 1'b1;
				if (stat.scan_last) begin
					cmd.scan_clr = 1'b1;
					state_nx     = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
				if (stat.scan_last) begin
					state_nx = ST_POP;
				end
			end
			ST_POP: begin
				cmd.pop  = 1'b1;
				state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

// File: hdl/mlsbs_datapath.sv
// Datapath of the multilevel slot budget scheduler: level state, scan and result.
module mlsbs_datapath #(
	parameter int NUM_LEVELS  = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mlsbs_pkg::ctl_cmd_t cmd,
	output mlsbs_pkg::dp_stat_t stat,
	input  logic [1:0]          s_tuser,
	input  logic [23:0]         s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic                m_tuser,
	output logic [23:0]         m_tdata
);
	import mlsbs_pkg::*;

	localparam int LW      = $clog2(NUM_LEVELS);
	localparam int HW      = $clog2(QUEUE_DEPTH);
	localparam int CW      = $clog2(QUEUE_DEPTH + 1);
	localparam int SW      = $clog2(NUM_LEVELS + 1);
	localparam int ENTRIES = NUM_LEVELS * QUEUE_DEPTH;
	localparam int AW      = $clog2(ENTRIES);
	localparam int TW      = $clog2(ENTRIES + 1);

	logic [1:0]         op_q;
	logic [7:0]         prio_q;
	logic [ID_BITS-1:0] pid_q;

	logic [HW-1:0]    head_q  [NUM_LEVELS];
	logic [CW-1:0]    count_q [NUM_LEVELS];
	logic [SW-1:0]    slots_q [NUM_LEVELS];
	logic [TAG_W-1:0] tag_q   [NUM_LEVELS];
	logic [TW-1:0]    total_q;
	logic [LW-1:0]    scan_q;

	logic             any_q, hit_lo_q, hit_hi_q, hit_fb_q;
	logic [TAG_W-1:0] lo_q, hi_q;
	logic [LW-1:0]    lv_lo_q, lv_hi_q, lv_fb_q;
	logic             res_granted_q, res_rejected_q;
	logic [LW-1:0]    res_level_q;

	// enqueue path
	logic          lvl_ok, enq_ok;
	logic [LW-1:0] lvl_in;
	logic [CW:0]   wr_sum, wr_wrap;
	logic [HW-1:0] wr_pos;
	logic [AW-1:0] wr_addr;

	// scan path
	logic             sc_full, sc_quota;
	logic [TAG_W-1:0] sc_tag;

	// pop path
	logic          bump;
	logic [LW-1:0] pick;
	logic [HW-1:0] pick_head, head_nx;
	logic [AW-1:0] rd_addr;
	logic [ID_BITS-1:0] rd_data;

	assign lvl_in  = prio_q[LW-1:0];
	assign lvl_ok  = {1'b0, prio_q} < 9'(NUM_LEVELS);
	assign enq_ok  = lvl_ok && (count_q[lvl_in] != CW'(QUEUE_DEPTH));
	assign wr_sum  = (CW+1)'(head_q[lvl_in]) + (CW+1)'(count_q[lvl_in]);
	assign wr_wrap = (wr_sum >= (CW+1)'(QUEUE_DEPTH)) ? wr_sum - (CW+1)'(QUEUE_DEPTH) : wr_sum;
	assign wr_pos  = wr_wrap[HW-1:0];
	assign wr_addr = AW'(lvl_in) * AW'(QUEUE_DEPTH) + AW'(wr_pos);

	assign sc_full  = count_q[scan_q] != '0;
	assign sc_tag   = tag_q[scan_q];
	assign sc_quota = slots_q[scan_q] < (SW'(NUM_LEVELS) - SW'(scan_q));

	assign bump      = !hit_lo_q && !hit_hi_q;
	assign pick      = hit_lo_q ? lv_lo_q : (hit_hi_q ? lv_hi_q : lv_fb_q);
	assign pick_head = head_q[pick];
	assign head_nx   = (pick_head == HW'(QUEUE_DEPTH - 1)) ? '0 : pick_head + HW'(1);
	assign rd_addr   = AW'(pick) * AW'(QUEUE_DEPTH) + AW'(pick_head);

	mlsbs_ram #(.WIDTH(ID_BITS), .DEPTH(ENTRIES)) u_ram (
		.clk     (clk),
		.wr_en   (cmd.enq && enq_ok),
		.wr_addr (wr_addr),
		.wr_data (pid_q),
		.rd_en   (cmd.pop),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign stat.op          = op_q;
	assign stat.none_queued = total_q == '0;
	assign stat.scan_last   = scan_q == LW'(NUM_LEVELS - 1);
	assign stat.out_busy    = m_tvalid && !m_tready;

	// request and scan payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= s_tuser;
			prio_q <= s_tdata[7:0];
			pid_q  <= ID_BITS'(s_tdata[23:8]);
		end
		if (cmd.minmax && sc_full) begin
			if (!any_q || sc_tag < lo_q) lo_q <= sc_tag;
			if (!any_q || sc_tag > hi_q) hi_q <= sc_tag;
		end
		if (cmd.match && sc_full) begin
			if (!hit_lo_q && sc_quota && sc_tag == lo_q) lv_lo_q <= scan_q;
			if (!hit_hi_q && sc_quota && sc_tag == hi_q) lv_hi_q <= scan_q;
			if (!hit_fb_q && sc_tag == lo_q)             lv_fb_q <= scan_q;
		end
		if (cmd.pop) begin
			res_level_q <= pick;
		end
		if (cmd.finish) begin
			m_tuser       <= res_granted_q;
			m_tdata[15:0] <= res_granted_q ? 16'(rd_data) : 16'd0;
			m_tdata[18:16] <= res_granted_q ? 3'(res_level_q) : 3'd0;
			m_tdata[19]   <= res_rejected_q;
			m_tdata[20]   <= total_q == '0;
			m_tdata[23:21] <= 3'd0;
		end
	end

	// level state and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
				slots_q[i] <= '0;
				tag_q[i]   <= '0;
			end
			total_q        <= '0;
			scan_q         <= '0;
			any_q          <= 1'b0;
			hit_lo_q       <= 1'b0;
			hit_hi_q       <= 1'b0;
			hit_fb_q       <= 1'b0;
			res_granted_q  <= 1'b0;
			res_rejected_q <= 1'b0;
			m_tvalid       <= 1'b0;
		end else begin
			if (cmd.load) begin
				any_q          <= 1'b0;
				hit_lo_q       <= 1'b0;
				hit_hi_q       <= 1'b0;
				hit_fb_q       <= 1'b0;
				res_granted_q  <= 1'b0;
				res_rejected_q <= 1'b0;
			end
			if (cmd.scan_clr) begin
				scan_q <= '0;
			end else if (cmd.minmax || cmd.match) begin
				scan_q <= scan_q + LW'(1);
			end
			if (cmd.minmax && sc_full) begin
				any_q <= 1'b1;
			end
			if (cmd.match && sc_full) begin
				if (sc_quota && sc_tag == lo_q) hit_lo_q <= 1'b1;
				if (sc_quota && sc_tag == hi_q) hit_hi_q <= 1'b1;
				if (sc_tag == lo_q)             hit_fb_q <= 1'b1;
			end
			if (cmd.enq) begin
				if (enq_ok) begin
					count_q[lvl_in] <= count_q[lvl_in] + CW'(1);
					total_q         <= total_q + TW'(1);
				end else begin
					res_rejected_q <= 1'b1;
				end
			end
			if (cmd.pop) begin
				head_q[pick]  <= head_nx;
				count_q[pick] <= count_q[pick] - CW'(1);
				total_q       <= total_q - TW'(1);
				res_granted_q <= 1'b1;
				if (bump) begin
					slots_q[pick] <= SW'(1);
					if (tag_q[pick] != TAG_MAX) tag_q[pick] <= tag_q[pick] + TAG_W'(1);
				end else begin
					slots_q[pick] <= slots_q[pick] + SW'(1);
				end
			end
			if (cmd.clear) begin
				for (int i = 0; i < NUM_LEVELS; i++) begin
					slots_q[i] <= '0;
					tag_q[i]   <= '0;
				end
			end
			if (cmd.finish) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/multilevel_slot_budget_scheduler.sv
// Top level of the multilevel slot budget scheduler.
//
//  channel | role   | tuser            | tdata
//  s_*     | input  | operation [1:0]  | priority_req [7:0], process_id [23:8]
//  m_*     | output | granted [0]      | granted_id [15:0], granted_level [18:16],
//          |        |                  | rejected [19], all_empty [20]
//
// One request at a time. Enqueue, clear and unused operations, and a dequeue with
// nothing queued, go from decode straight to the result; a dequeue with something
// queued first runs the two passes of the level scan (min/max tags, then candidate
// levels), which visit one level per cycle, and then pops the chosen level before
// m_tvalid is raised.
// arst_n clears all level state; FIFO storage needs no clearing pass.
// A held result waits in the output register; the next request is taken
// once the result register has been loaded.
module multilevel_slot_budget_scheduler #(
	parameter int NUM_LEVELS  = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // operation [1:0]
	input  logic [23:0] s_tdata,  // priority_req [7:0], process_id [23:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        m_tuser,  // granted [0]
	output logic [23:0] m_tdata   // granted_id, granted_level, rejected, all_empty, zero
);
	import mlsbs_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// ready only while the controller waits for a request
	assign s_tready = cmd.accept;

	mlsbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.cmd      (cmd)
	);

	mlsbs_datapath #(
		.NUM_LEVELS  (NUM_LEVELS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

endmodule

// File: hdl/mlsbs_checker.sv
// Port-level checker of the multilevel slot budget scheduler, with its bind.
module mlsbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic [23:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic        m_tuser,
	input logic [23:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in work");

	a_grant_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[19])
		else $error("grant and reject on one result");

	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[18:0] == 19'd0)
		else $error("id or level set without a grant");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("offered request changed before it was taken");

endmodule

bind multilevel_slot_budget_scheduler mlsbs_checker u_mlsbs_checker (.*);

// File: verif/multilevel_slot_budget_scheduler_test.sv
// Self-checking testbench for the multilevel slot budget scheduler.
`timescale 1ns / 1ps

module multilevel_slot_budget_scheduler_test;
	import mlsbs_pkg::*;

	localparam int LEVELS = 8;
	localparam int DEPTH  = 16;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  prio;
		logic [15:0] pid;
	} sched_req_t;

	typedef struct packed {
		logic        granted;
		logic [15:0] gid;
		logic [2:0]  glevel;
		logic        rejected;
		logic        all_empty;
	} sched_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;   // operation [1:0]
	logic [23:0] s_tdata;   // priority_req [7:0], process_id [23:8]
	logic        m_tvalid;
	logic        m_tready;
	logic        m_tuser;   // granted [0]
	logic [23:0] m_tdata;   // granted_id [15:0], granted_level [18:16], rejected [19],
	                        // all_empty [20]

	multilevel_slot_budget_scheduler #(
		.NUM_LEVELS (LEVELS),
		.QUEUE_DEPTH(DEPTH),
		.ID_BITS    (16)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tuser (m_tuser),
		.m_tdata (m_tdata)
	);

	// Shadow copy of the scheduler state
	logic [15:0] fifo_ids [LEVELS][DEPTH];
	int unsigned fifo_head [LEVELS];
	int unsigned fifo_fill [LEVELS];
	int unsigned slots_taken [LEVELS];
	logic [15:0] level_tag [LEVELS];

	sched_req_t pending_reqs[$];
	sched_res_t expected_results[$];
	int unsigned errors = 0;
	bit stimulus_done = 0;
	bit long_hold = 0;
	bit req_taken = 0;

	// Pick the level a dequeue serves; LEVELS when nothing is queued.
	function automatic int unsigned choose_level();
		bit any;
		logic [15:0] lo, hi;
		any = 0;
		lo = '0;
		hi = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (fifo_fill[l] == 0) continue;
			if (!any) begin
				lo = level_tag[l];
				hi = level_tag[l];
				any = 1;
			end else begin
				if (level_tag[l] < lo) lo = level_tag[l];
				if (level_tag[l] > hi) hi = level_tag[l];
			end
		end
		if (!any) return LEVELS;
		// first pass: minimum tag with quota left
		for (int l = 0; l < LEVELS; l++)
			if (fifo_fill[l] != 0 && slots_taken[l] < LEVELS - l && level_tag[l] == lo) begin
				slots_taken[l]++;
				return l;
			end
		// second pass: maximum tag with quota left
		for (int l = 0; l < LEVELS; l++)
			if (fifo_fill[l] != 0 && slots_taken[l] < LEVELS - l && level_tag[l] == hi) begin
				slots_taken[l]++;
				return l;
			end
		// no quota anywhere: open a new cycle on the first minimum-tag level
		for (int l = 0; l < LEVELS; l++)
			if (fifo_fill[l] != 0 && level_tag[l] == lo) begin
				if (level_tag[l] != TAG_MAX) level_tag[l]++;
				slots_taken[l] = 1;
				return l;
			end
		return LEVELS;
	endfunction

	function automatic sched_res_t schedule_request(sched_req_t r);
		sched_res_t res;
		int unsigned l;
		res = '0;
		case (r.op)
			OP_ENQ: begin
				if (r.prio >= LEVELS || fifo_fill[r.prio] >= DEPTH) begin
					res.rejected = 1;
				end else begin
					l = r.prio;
					fifo_ids[l][(fifo_head[l] + fifo_fill[l]) % DEPTH] = r.pid;
					fifo_fill[l]++;
				end
			end
			OP_DEQ: begin
				l = choose_level();
				if (l < LEVELS) begin
					res.granted = 1;
					res.gid = fifo_ids[l][fifo_head[l]];
					res.glevel = l[2:0];
					fifo_head[l] = (fifo_head[l] + 1) % DEPTH;
					fifo_fill[l]--;
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < LEVELS; i++) begin
					slots_taken[i] = 0;
					level_tag[i] = '0;
				end
			end
			default: ;
		endcase
		res.all_empty = 1;
		for (int i = 0; i < LEVELS; i++)
			if (fifo_fill[i] != 0) res.all_empty = 0;
		return res;
	endfunction

	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		return $urandom_range(0, 3);
	endfunction

	initial clk = 0;
	always #6 clk = ~clk;

	// Driver: offer queued requests with random gaps
	int unsigned send_gap = 0;
	always @(negedge clk) begin
		req_taken <= 1'b0;
		if (!arst_n) begin
			s_tvalid <= 0;
		end else if (s_tvalid && !req_taken) begin
			// hold the offered request
		end else if (send_gap != 0) begin
			send_gap <= send_gap - 1;
			s_tvalid <= 0;
		end else if (pending_reqs.size() != 0) begin
			sched_req_t r;
			r = pending_reqs.pop_front();
			s_tvalid <= 1;
			s_tuser <= r.op;
			s_tdata <= {r.pid, r.prio};
			send_gap <= pick_gap();
		end else begin
			s_tvalid <= 0;
		end
	end

	// Predict at acceptance
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			sched_req_t r;
			r.op = s_tuser;
			r.prio = s_tdata[7:0];
			r.pid = s_tdata[23:8];
			expected_results.push_back(schedule_request(r));
			req_taken <= 1'b1;
		end
	end

	// Receiver stalls; one long hold-off is requested separately
	int unsigned stall_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else if (long_hold) begin
			m_tready <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 0;
		end else begin
			m_tready <= 1;
			if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
		end
	end

	initial begin
		wait (arst_n);
		repeat (60) @(posedge clk);
		long_hold = 1;
		repeat (400) @(posedge clk);
		long_hold = 0;
	end

	// Monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sched_res_t got, want;
			got = {m_tuser, m_tdata[15:0], m_tdata[18:16], m_tdata[19], m_tdata[20]};
			if (m_tdata[23:21] != 0) begin
				errors++;
				$display("%0t: padding bits expected 0 actual %h", $time, m_tdata[23:21]);
			end
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual %h", $time, got);
			end else begin
				want = expected_results.pop_front();
				if (got.granted !== want.granted)
					$display("%0t: granted expected %0d actual %0d", $time, want.granted,
						got.granted);
				if (got.gid !== want.gid)
					$display("%0t: granted_id expected %h actual %h", $time, want.gid, got.gid);
				if (got.glevel !== want.glevel)
					$display("%0t: granted_level expected %0d actual %0d", $time,
						want.glevel, got.glevel);
				if (got.rejected !== want.rejected)
					$display("%0t: rejected expected %0d actual %0d", $time, want.rejected,
						got.rejected);
				if (got.all_empty !== want.all_empty)
					$display("%0t: all_empty expected %0d actual %0d", $time,
						want.all_empty, got.all_empty);
				if (got !== want) errors++;
			end
		end
	end

	function automatic sched_req_t make_req(logic [1:0] op, logic [7:0] prio, logic [15:0] pid);
		sched_req_t r;
		r.op = op;
		r.prio = prio;
		r.pid = pid;
		return r;
	endfunction

	// Stimulus
	initial begin
		int unsigned n;
		int unsigned k;
		s_tvalid = 0;
		s_tuser = '0;
		s_tdata = '0;
		m_tready = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: empty dequeue, bad levels, extremes, spare and clear
		pending_reqs.push_back(make_req(OP_DEQ, 8'h00, 16'h0000));
		pending_reqs.push_back(make_req(OP_ENQ, 8'd8, 16'hFFFF));
		pending_reqs.push_back(make_req(OP_ENQ, 8'hFF, 16'h1234));
		pending_reqs.push_back(make_req(OP_ENQ, 8'd0, 16'hFFFF));
		pending_reqs.push_back(make_req(OP_ENQ, 8'd7, 16'h0000));
		pending_reqs.push_back(make_req(OP_SPARE, 8'hFF, 16'hFFFF));
		pending_reqs.push_back(make_req(OP_DEQ, 8'hFF, 16'hFFFF));
		pending_reqs.push_back(make_req(OP_CLEAR, 8'hAA, 16'h5555));
		pending_reqs.push_back(make_req(OP_DEQ, 8'h00, 16'h0000));
		pending_reqs.push_back(make_req(OP_DEQ, 8'h00, 16'h0000));
		// fill level 3 past full
		for (int i = 0; i < DEPTH + 1; i++)
			pending_reqs.push_back(make_req(OP_ENQ, 8'd3, 16'(i * 16'h0F0F)));

		// random: mostly enqueue/dequeue, with dequeues slightly ahead to exhaust quotas
		n = 0;
		while (n < 900) begin
			k = $urandom_range(0, 99);
			if (k < 45)
				pending_reqs.push_back(make_req(OP_ENQ,
					($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
					16'($urandom)));
			else if (k < 93)
				pending_reqs.push_back(make_req(OP_DEQ, 8'($urandom), 16'($urandom)));
			else if (k < 97)
				pending_reqs.push_back(make_req(OP_CLEAR, 8'($urandom), 16'($urandom)));
			else
				pending_reqs.push_back(make_req(OP_SPARE, 8'($urandom), 16'($urandom)));
			n++;
		end
		stimulus_done = 1;

		wait (pending_reqs.size() == 0 && !s_tvalid);
		wait (expected_results.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("multilevel_slot_budget_scheduler: match");
		else
			$display("multilevel_slot_budget_scheduler: mismatch");
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("multilevel_slot_budget_scheduler: mismatch");
		$finish;
	end

endmodule
